// ----- design/wsfp_pkg.sv -----
`timescale 1ns / 1ps

package wsfp_pkg;

    localparam int LEN_W = 63;
    localparam int ACC_W = 64;

    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_PAY = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [2:0] ERR_BAD_OPCODE = 3'd0;
    localparam logic [2:0] ERR_FRAG_CTRL  = 3'd1;
    localparam logic [2:0] ERR_EXP_CONT   = 3'd2;
    localparam logic [2:0] ERR_CTRL_LONG  = 3'd3;
    localparam logic [2:0] ERR_NONMIN_LEN = 3'd4;
    localparam logic [2:0] ERR_LEN_MSB    = 3'd5;
    localparam logic [2:0] ERR_UNEXP_MASK = 3'd6;
    localparam logic [2:0] ERR_MISS_MASK  = 3'd7;

    localparam logic [3:0] OP_CONT     = 4'd0;
    localparam logic [3:0] OP_BIN      = 4'd2;
    localparam logic [3:0] OP_CTRL_LO  = 4'd8;
    localparam logic [3:0] OP_CTRL_HI  = 4'd10;

    localparam logic [6:0] CTRL_MAX_LEN = 7'd125;
    localparam logic [6:0] LEN7_EXT16   = 7'd126;
    localparam logic [6:0] LEN7_EXT64   = 7'd127;

    localparam logic [ACC_W-1:0] EXT16_MAX_SHORT = 64'd125;
    localparam logic [ACC_W-1:0] EXT64_MAX_SHORT = 64'd65535;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef enum logic [4:0] {
        PH_HDR1 = 5'b00001,
        PH_HDR2 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_PAY  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [1:0]       kind;
        logic [3:0]       opcode;
        logic             fin;
        logic [2:0]       rsv;
        logic             masked;
        logic [LEN_W-1:0] len;
        logic [7:0]       data;
        logic [2:0]       err;
        logic             last;
    } t_result;

    function automatic t_result wsfp_frame(input logic [1:0] kind, input logic [7:0] fhb,
                                           input logic [3:0] frag_op, input logic masked,
                                           input logic [LEN_W-1:0] len);
        t_result r;
        r        = '0;
        r.kind   = kind;
        r.opcode = (!fhb[3] && !fhb[7]) ? frag_op : fhb[3:0];
        r.fin    = fhb[7];
        r.rsv    = fhb[6:4];
        r.masked = masked;
        r.len    = len;
        return r;
    endfunction

    function automatic t_result wsfp_error(input logic [2:0] code);
        t_result r;
        r      = '0;
        r.kind = KIND_ERR;
        r.err  = code;
        r.last = 1'b1;
        return r;
    endfunction

endpackage

// ----- design/websocket_frame_parser.sv -----
// Path: a result reaches m_axis through the input register, then parse logic into the output register.
// Throughput: one byte per cycle while the output stage has space; a two-entry output stage keeps s_axis_tready
//   high while one result waits on m_axis.
// Reset: synchronous, active low; parser returns to header phase, role is client.
`timescale 1ns / 1ps

module websocket_frame_parser import wsfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] frame_opcode, [4] fin_flag, [7:5] rsv_bits, [8] was_masked,
    // [71:9] pay_len, [79:72] data_byte, [82:80] error_code, [87:83] zero
    output logic [87:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,  // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_ROLE = 1'b0;

    logic    r_role_is_server;
    logic    space;
    logic    push;
    t_result core_res;
    t_result out_res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROLE) ? {31'b0, r_role_is_server} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role_is_server <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROLE) begin
            r_role_is_server <= pwdata[0];
        end
    end

    wsfp_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_role_is_server (r_role_is_server),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_byte           (s_axis_tdata),
        .i_space          (space),
        .o_push           (push),
        .o_res            (core_res)
    );

    wsfp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (core_res),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {5'b0, out_res.err, out_res.data, out_res.len, out_res.masked,
                           out_res.rsv, out_res.fin, out_res.opcode};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

// ----- design/wsfp_core.sv -----
`timescale 1ns / 1ps

module wsfp_core import wsfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_role_is_server,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_space,
    output logic       o_push,
    output t_result    o_res
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    t_phase           r_phase, n_phase;
    logic [3:0]       r_cnt, n_cnt;
    logic [ACC_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_left, n_left;
    logic [31:0]      r_key, n_key;
    logic [1:0]       r_midx, n_midx;
    logic [7:0]       r_fhb, n_fhb;
    logic             r_mask_seen, n_mask_seen;
    logic             r_ext_long, n_ext_long;
    logic             r_frag_active, n_frag_active;
    logic [3:0]       r_frag_op, n_frag_op;

    logic             fire;
    logic [3:0]       op;
    logic             fin;
    logic             ctl;
    logic [6:0]       len7;
    logic [ACC_W-1:0] acc_next;
    logic [7:0]       key_byte;
    logic             do_after;
    logic             do_finish;
    logic             err_hit;
    logic [2:0]       err_code;
    logic             res_valid;
    t_result          res;

    assign fire     = r_in_valid && i_space;
    assign o_ready  = !r_in_valid || i_space;
    assign op       = r_fhb[3:0];
    assign fin      = r_fhb[7];
    assign ctl      = op[3];
    assign len7     = r_in_byte[6:0];
    assign acc_next = {r_len[ACC_W-9:0], r_in_byte};
    assign o_push   = res_valid;
    assign o_res    = res;

    always_comb begin
        case (r_midx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_cnt         = r_cnt;
        n_len         = r_len;
        n_left        = r_left;
        n_key         = r_key;
        n_midx        = r_midx;
        n_fhb         = r_fhb;
        n_mask_seen   = r_mask_seen;
        n_ext_long    = r_ext_long;
        n_frag_active = r_frag_active;
        n_frag_op     = r_frag_op;
        res_valid     = 1'b0;
        res           = '0;
        do_after      = 1'b0;
        do_finish     = 1'b0;
        err_hit       = 1'b0;
        err_code      = ERR_BAD_OPCODE;
        if (fire) begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_fhb   = r_in_byte;
                    n_phase = PH_HDR2;
                end
                PH_HDR2: begin
                    n_mask_seen = r_in_byte[7];
                    if ((op > OP_BIN && op < OP_CTRL_LO) || op > OP_CTRL_HI) begin
                        err_hit  = 1'b1;
                        err_code = ERR_BAD_OPCODE;
                    end else if (ctl && !fin) begin
                        err_hit  = 1'b1;
                        err_code = ERR_FRAG_CTRL;
                    end else if (r_frag_active && !ctl && op != OP_CONT) begin
                        err_hit  = 1'b1;
                        err_code = ERR_EXP_CONT;
                    end else if (ctl && len7 > CTRL_MAX_LEN) begin
                        err_hit  = 1'b1;
                        err_code = ERR_CTRL_LONG;
                    end else if (len7 >= LEN7_EXT16) begin
                        n_ext_long = (len7 == LEN7_EXT64);
                        n_cnt      = (len7 == LEN7_EXT64) ? EXT64_BYTES : EXT16_BYTES;
                        n_len      = '0;
                        n_phase    = PH_EXT;
                    end else begin
                        n_len    = {{(ACC_W-7){1'b0}}, len7};
                        do_after = 1'b1;
                    end
                end
                PH_EXT: begin
                    n_len = acc_next;
                    n_cnt = r_cnt - 4'd1;
                    if (r_cnt == 4'd1) begin
                        if (!r_ext_long && acc_next <= EXT16_MAX_SHORT) begin
                            err_hit  = 1'b1;
                            err_code = ERR_NONMIN_LEN;
                        end else if (r_ext_long && acc_next <= EXT64_MAX_SHORT) begin
                            err_hit  = 1'b1;
                            err_code = ERR_NONMIN_LEN;
                        end else if (r_ext_long && acc_next[ACC_W-1]) begin
                            err_hit  = 1'b1;
                            err_code = ERR_LEN_MSB;
                        end else begin
                            do_after = 1'b1;
                        end
                    end
                end
                PH_KEY: begin
                    n_key = {r_key[23:0], r_in_byte};
                    n_cnt = r_cnt - 4'd1;
                    if (r_cnt == 4'd1) begin
                        do_finish = 1'b1;
                    end
                end
                PH_PAY: begin
                    res_valid = 1'b1;
                    res       = wsfp_frame(KIND_PAY, r_fhb, r_frag_op, r_mask_seen,
                                           r_len[LEN_W-1:0]);
                    res.data  = r_mask_seen ? (r_in_byte ^ key_byte) : r_in_byte;
                    n_midx    = r_midx + 2'd1;
                    n_left    = r_left - {{(LEN_W-1){1'b0}}, 1'b1};
                    if (r_left == {{(LEN_W-1){1'b0}}, 1'b1}) begin
                        res.last = 1'b1;
                        n_phase  = PH_HDR1;
                    end
                end
                default: begin
                    n_phase = PH_HDR1;
                    n_cnt   = '0;
                end
            endcase

            if (do_after) begin
                if (n_mask_seen && !i_role_is_server) begin
                    err_hit  = 1'b1;
                    err_code = ERR_UNEXP_MASK;
                end else if (!n_mask_seen && i_role_is_server) begin
                    err_hit  = 1'b1;
                    err_code = ERR_MISS_MASK;
                end else if (n_mask_seen) begin
                    n_cnt   = KEY_BYTES;
                    n_phase = PH_KEY;
                end else begin
                    do_finish = 1'b1;
                end
            end

            if (do_finish) begin
                n_midx = '0;
                if (!ctl) begin
                    if (fin) begin
                        n_frag_active = 1'b0;
                    end else if (!r_frag_active) begin
                        n_frag_active = 1'b1;
                        n_frag_op     = op;
                    end
                end
                res_valid = 1'b1;
                res       = wsfp_frame(KIND_HDR, r_fhb, n_frag_op, n_mask_seen,
                                       n_len[LEN_W-1:0]);
                n_left    = n_len[LEN_W-1:0];
                n_cnt     = '0;
                if (n_len == '0) begin
                    res.last = 1'b1;
                    n_phase  = PH_HDR1;
                end else begin
                    n_phase = PH_PAY;
                end
            end

            if (err_hit) begin
                res_valid = 1'b1;
                res       = wsfp_error(err_code);
                n_phase   = PH_HDR1;
                n_cnt     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR1;
            r_cnt         <= '0;
            r_midx        <= '0;
            r_fhb         <= '0;
            r_mask_seen   <= 1'b0;
            r_ext_long    <= 1'b0;
            r_frag_active <= 1'b0;
            r_frag_op     <= '0;
        end else begin
            r_phase       <= n_phase;
            r_cnt         <= n_cnt;
            r_midx        <= n_midx;
            r_fhb         <= n_fhb;
            r_mask_seen   <= n_mask_seen;
            r_ext_long    <= n_ext_long;
            r_frag_active <= n_frag_active;
            r_frag_op     <= n_frag_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_left <= n_left;
        r_key  <= n_key;
    end

`ifndef SYNTHESIS
    a_err_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res.kind == KIND_ERR |-> res.last && n_phase == PH_HDR1)
        else $error("error result does not end the frame");
    a_pay_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res.kind == KIND_PAY |-> r_phase == PH_PAY)
        else $error("payload result outside payload phase");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !i_space |=> r_in_valid && $stable(r_in_byte))
        else $error("held input byte lost during stall");
    a_push_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> fire)
        else $error("result without a consumed byte");
`endif

endmodule

// ----- design/wsfp_out_stage.sv -----
`timescale 1ns / 1ps

module wsfp_out_stage import wsfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;

    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || i_ready) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || i_ready) begin
                r_main <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry without a head entry");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("request pushed into a full output stage");
    a_skid_promotes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_ready |=> r_main_valid && !r_skid_valid)
        else $error("skid entry not moved to head");
`endif

endmodule
